// ===== rtl/lztbw_pkg.sv =====
`timescale 1ns / 1ps
package lztbw_pkg;

  localparam int BUF_DEPTH = 10;
  localparam int BUF_IDX_W = 4;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_LIT  = 2'd1;
  localparam logic [1:0] KIND_COPY = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic CFG_INIT_OFFSET = 1'b0;
  localparam logic CFG_INIT_MARGIN = 1'b1;

  localparam logic signed [18:0] MARGIN_HI = 19'sd131071;
  localparam logic signed [18:0] MARGIN_LO = -19'sd131072;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_BIT,
    ACT_BYTE,
    ACT_GLOAD,
    ACT_GSTEP,
    ACT_READ,
    ACT_FLUSH,
    ACT_DRAIN
  } act_t;

  typedef enum logic {
    BSEL_LIT,
    BSEL_OFF
  } byte_sel_t;

  typedef enum logic [1:0] {
    GSEL_LEN,
    GSEL_OFFHI,
    GSEL_LENM1,
    GSEL_END
  } gsel_t;

  typedef struct packed {
    act_t      act;
    logic      bit_val;
    byte_sel_t byte_sel;
    gsel_t     gsel;
    logic      gskip;
    logic      clear_first;
    logic      set_last_off;
    logic      restart;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       rep;
    logic       first;
    logic       gdone;
    logic       drain_end;
  } ctl_status_t;

endpackage

// ===== rtl/lztbw_datapath.sv =====
`timescale 1ns / 1ps
module lztbw_datapath
  import lztbw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                cmd,
  output ctl_status_t             status,
  input  logic [1:0]              in_kind,
  input  logic [15:0]             in_length,
  input  logic [15:0]             in_offset,
  input  logic [7:0]              in_literal,
  input  logic                    cfg_we,
  input  logic                    cfg_sel,
  input  logic [17:0]             cfg_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_addr,
  output logic [7:0]              out_value,
  output logic                    out_last,
  output logic [16:0]             out_margin
);

  logic [15:0] init_off;
  logic [17:0] init_margin;
  logic        idle;

  logic [1:0]  kind;
  logic [15:0] len;
  logic [15:0] off;
  logic [7:0]  lit;
  logic        rep;

  logic [15:0] next_addr;
  logic [7:0]  bit_byte;
  logic [15:0] bb_addr;
  logic [3:0]  bits_left;
  logic [15:0] last_off;
  logic        first;
  logic signed [17:0] margin;
  logic [16:0] peak;

  logic [15:0] gdata;
  logic [3:0]  gk;
  logic        gphase;
  logic        gskip;
  logic        gdone;

  logic [15:0] buf_addr [BUF_DEPTH];
  logic [7:0]  buf_val  [BUF_DEPTH];
  logic [BUF_IDX_W-1:0] count;
  logic [BUF_IDX_W-1:0] rd;

  logic [15:0] o1;
  logic [7:0]  byte_v;
  logic        g_emit, g_bit, bit_req, bit_v, bl0, take, pop;
  logic [3:0]  blv, nbl;
  logic [7:0]  bbv, nb;
  logic [15:0] bav;
  logic        emit_req;
  logic [15:0] emit_addr;
  logic [7:0]  emit_val;
  logic signed [18:0] delta, msum, msat;
  logic [16:0] peak_next;
  logic [15:0] gv, gtop, gd;
  logic [3:0]  gbits;
  logic [15:0] len_in;

  assign o1     = off - 16'd1;
  assign len_in = (in_length == 16'd0) ? 16'd1 : in_length;
  assign byte_v = (cmd.byte_sel == BSEL_LIT) ? lit : {o1[6:0], (len == 16'd2)};
  assign gdone  = (gk == 4'd0);

  always_comb begin
    g_emit = 1'b0;
    g_bit  = 1'b0;
    if (cmd.act == ACT_GSTEP) begin
      if (gk != 4'd0) begin
        if (gphase) begin
          g_emit = 1'b1;
          g_bit  = gdata[gk - 4'd1];
        end else if (!gskip) begin
          g_emit = 1'b1;
        end
      end else if (!gskip) begin
        g_emit = 1'b1;
        g_bit  = 1'b1;
      end
    end
    bit_req = (cmd.act == ACT_BIT) || g_emit;
    bit_v   = (cmd.act == ACT_BIT) ? cmd.bit_val : g_bit;
    bl0     = (bits_left == 4'd0);
    blv     = bl0 ? 4'd8 : bits_left;
    bbv     = bl0 ? 8'd0 : bit_byte;
    bav     = bl0 ? next_addr : bb_addr;
    nbl     = blv - 4'd1;
    nb      = bbv | (8'(bit_v) << nbl[2:0]);

    emit_req  = 1'b0;
    emit_addr = next_addr;
    emit_val  = byte_v;
    if (cmd.act == ACT_BYTE) begin
      emit_req = 1'b1;
    end else if (bit_req && nbl == 4'd0) begin
      emit_req  = 1'b1;
      emit_addr = bav;
      emit_val  = nb;
    end else if (cmd.act == ACT_FLUSH && !bl0) begin
      emit_req  = 1'b1;
      emit_addr = bb_addr;
      emit_val  = bit_byte;
    end
    take = (cmd.act == ACT_BYTE) || (bit_req && bl0);

    if (cmd.act == ACT_READ) begin
      delta = (kind == KIND_LIT) ? 19'sd1 : $signed({3'b000, len});
    end else if (take) begin
      delta = -19'sd1;
    end else begin
      delta = 19'sd0;
    end
    msum = $signed({margin[17], margin}) + delta;
    if (msum > MARGIN_HI) begin
      msat = MARGIN_HI;
    end else if (msum < MARGIN_LO) begin
      msat = MARGIN_LO;
    end else begin
      msat = msum;
    end
    peak_next = peak;
    if (cmd.act == ACT_READ && msat > 19'sd0 && msat[16:0] > peak) begin
      peak_next = msat[16:0];
    end
  end

  always_comb begin
    case (cmd.gsel)
      GSEL_LEN:   gv = len;
      GSEL_OFFHI: gv = {7'd0, o1[15:7]} + 16'd1;
      GSEL_LENM1: gv = len - 16'd1;
      GSEL_END:   gv = 16'd256;
      default:    gv = len;
    endcase
    gbits = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (gv[i]) gbits = 4'(i);
    end
    gtop = 16'd1 << gbits;
    gd   = gv;
    if (gbits >= 4'd8) begin
      gd = gv & ~gtop;
      gd = (gd >> 8) | ((gd & 16'h00ff) << (gbits - 4'd8));
    end
  end

  assign pop        = out_valid && out_ready;
  assign out_valid  = (cmd.act == ACT_DRAIN) && (rd < count);
  assign out_addr   = buf_addr[rd];
  assign out_value  = buf_val[rd];
  assign out_last   = (rd == count - 4'd1);
  assign out_margin = peak;

  assign status.kind      = kind;
  assign status.rep       = rep;
  assign status.first     = first;
  assign status.gdone     = gdone;
  assign status.drain_end = (count == 4'd0) || (pop && out_last);

  always_ff @(posedge clk) begin
    if (emit_req && count < 4'(BUF_DEPTH)) begin
      buf_addr[count] <= emit_addr;
      buf_val[count]  <= emit_val;
    end
    if (cmd.act == ACT_LOAD) begin
      kind <= in_kind;
      len  <= len_in;
      off  <= in_offset;
      lit  <= in_literal;
      rep  <= (in_offset == last_off);
    end
    if (cmd.act == ACT_GLOAD) begin
      gdata <= gd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_off    <= 16'd1;
      init_margin <= 18'd0;
      idle        <= 1'b1;
      next_addr   <= 16'd0;
      bit_byte    <= 8'd0;
      bb_addr     <= 16'd0;
      bits_left   <= 4'd0;
      last_off    <= 16'd1;
      first       <= 1'b1;
      margin      <= 18'sd0;
      peak        <= 17'd0;
      gk          <= 4'd0;
      gphase      <= 1'b0;
      gskip       <= 1'b0;
      count       <= '0;
      rd          <= '0;
    end else if (cmd.restart) begin
      idle      <= 1'b1;
      next_addr <= 16'd0;
      bit_byte  <= 8'd0;
      bb_addr   <= 16'd0;
      bits_left <= 4'd0;
      last_off  <= init_off;
      first     <= 1'b1;
      margin    <= $signed(init_margin);
      peak      <= 17'd0;
      count     <= '0;
      rd        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_sel)
          CFG_INIT_OFFSET: begin
            init_off <= cfg_value[15:0];
            if (idle) last_off <= cfg_value[15:0];
          end
          CFG_INIT_MARGIN: begin
            init_margin <= cfg_value;
            if (idle) margin <= $signed(cfg_value);
          end
          default: ;
        endcase
      end
      if (cmd.act == ACT_LOAD) begin
        idle  <= 1'b0;
        count <= '0;
        rd    <= '0;
      end
      if (emit_req && count < 4'(BUF_DEPTH)) count <= count + 4'd1;
      if (take) next_addr <= next_addr + 16'd1;
      if (bit_req) begin
        bit_byte  <= nb;
        bb_addr   <= bav;
        bits_left <= nbl;
      end
      if (cmd.act == ACT_FLUSH) bits_left <= 4'd0;
      if (take || cmd.act == ACT_READ) margin <= msat[17:0];
      peak <= peak_next;
      if (cmd.clear_first) first <= 1'b0;
      if (cmd.set_last_off) last_off <= off;
      if (cmd.act == ACT_GLOAD) begin
        gk     <= gbits;
        gphase <= 1'b0;
        gskip  <= cmd.gskip;
      end
      if (cmd.act == ACT_GSTEP && gk != 4'd0) begin
        if (gphase) begin
          gk     <= gk - 4'd1;
          gphase <= 1'b0;
        end else begin
          gphase <= 1'b1;
          gskip  <= 1'b0;
        end
      end
      if (pop) rd <= rd + 4'd1;
    end
  end

endmodule

// ===== rtl/lztbw_ctrl.sv =====
`timescale 1ns / 1ps
module lztbw_ctrl
  import lztbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_GLOAD1,
    S_GSTEP1,
    S_MIDB,
    S_GLOAD2,
    S_GSTEP2,
    S_READ,
    S_FLUSH,
    S_DRAIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.act          = ACT_NOP;
    cmd.byte_sel     = BSEL_LIT;
    cmd.gsel         = GSEL_LEN;
    state_next       = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act    = ACT_LOAD;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        state_next = S_GLOAD1;
        case (status.kind)
          KIND_HDR: begin
            cmd.act         = status.first ? ACT_NOP : ACT_BIT;
            cmd.clear_first = 1'b1;
          end
          KIND_LIT: begin
            cmd.act    = ACT_BYTE;
            state_next = S_READ;
          end
          KIND_COPY: begin
            cmd.act     = ACT_BIT;
            cmd.bit_val = !status.rep;
          end
          KIND_END: begin
            cmd.act     = ACT_BIT;
            cmd.bit_val = 1'b1;
          end
          default: ;
        endcase
      end
      S_GLOAD1: begin
        cmd.act = ACT_GLOAD;
        if (status.kind == KIND_END) begin
          cmd.gsel = GSEL_END;
        end else if (status.kind == KIND_COPY && !status.rep) begin
          cmd.gsel = GSEL_OFFHI;
        end
        state_next = S_GSTEP1;
      end
      S_GSTEP1: begin
        cmd.act = ACT_GSTEP;
        if (status.gdone) begin
          case (status.kind)
            KIND_HDR:  state_next = S_DRAIN;
            KIND_COPY: state_next = status.rep ? S_READ : S_MIDB;
            KIND_END:  state_next = S_FLUSH;
            default:   state_next = S_DRAIN;
          endcase
        end
      end
      S_MIDB: begin
        cmd.act          = ACT_BYTE;
        cmd.byte_sel     = BSEL_OFF;
        cmd.set_last_off = 1'b1;
        state_next       = S_GLOAD2;
      end
      S_GLOAD2: begin
        cmd.act    = ACT_GLOAD;
        cmd.gsel   = GSEL_LENM1;
        cmd.gskip  = 1'b1;
        state_next = S_GSTEP2;
      end
      S_GSTEP2: begin
        cmd.act = ACT_GSTEP;
        if (status.gdone) state_next = S_READ;
      end
      S_READ: begin
        cmd.act    = ACT_READ;
        state_next = S_DRAIN;
      end
      S_FLUSH: begin
        cmd.act    = ACT_FLUSH;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.act = ACT_DRAIN;
        if (status.drain_end) begin
          cmd.restart = (status.kind == KIND_END);
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lz_token_bitstream_writer_top.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// s_axis    | in        | s_tvalid/s_tready  | tdata length,offset,literal_byte; tuser cmd
// m_axis    | out       | m_tvalid/m_tready  | tdata byte_addr,byte_value,max_margin; tlast
// cfg       | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one token is taken at a time; it runs through the sequencer one bit or byte per
// cycle, then its buffered byte writes (up to ten) drain one per cycle while m_tready is high
// a literal byte passes the load, byte, read and drain states; a gamma code has a load step,
// then a zero bit and the data bit for each data bit, and a closing one bit
// rst is synchronous and restores the register defaults and stream state
// m_tready low holds the drain; s_tready stays low until the drain completes
module lz_token_bitstream_writer_top
  import lztbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // length, offset, literal_byte
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // byte_addr, byte_value, max_margin, zero pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);

  ctl_cmd_t    cmd;
  ctl_status_t status;
  logic [15:0] out_addr;
  logic [7:0]  out_value;
  logic [16:0] out_margin;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, out_margin, out_value, out_addr};

  lztbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lztbw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_kind    (s_tuser),
    .in_length  (s_tdata[15:0]),
    .in_offset  (s_tdata[31:16]),
    .in_literal (s_tdata[39:32]),
    .cfg_we     (cfg_valid),
    .cfg_sel    (cfg_index),
    .cfg_value  (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_addr   (out_addr),
    .out_value  (out_value),
    .out_last   (m_tlast),
    .out_margin (out_margin)
  );

endmodule
